>>> design/glbcp_pkg.sv
// ----------------------------------------------------------------------------
// glbcp_pkg
// Shared types and constants for the GLB container chunk parser.
// ----------------------------------------------------------------------------
package glbcp_pkg;

    localparam int LENGTH_WIDTH_DEF   = 32;
    localparam int S_TDATA_W          = 8;
    localparam int M_TDATA_W          = 16;
    localparam int M_TUSER_W          = 3;
    localparam int HEADER_BYTES       = 12;
    localparam int CHUNK_HEADER_BYTES = 8;

    localparam logic [31:0] GLB_MAGIC   = 32'h4654_6C67;  // "glTF"
    localparam logic [31:0] GLB_VERSION = 32'd2;
    localparam logic [31:0] TYPE_JSON   = 32'h4E4F_534A;  // "JSON"
    localparam logic [31:0] TYPE_BIN    = 32'h004E_4942;  // "BIN\0"

    typedef enum logic [1:0] {
        PH_HEADER       = 2'd0,
        PH_CHUNK_HEADER = 2'd1,
        PH_PAYLOAD      = 2'd2,
        PH_ERROR        = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_JSON        = 3'd1,
        KIND_BIN         = 3'd2,
        KIND_SKIP        = 3'd3,
        KIND_AFTER_ERROR = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_SHORT          = 4'd1,
        ST_MAGIC          = 4'd2,
        ST_VERSION        = 4'd3,
        ST_LENGTH         = 4'd4,
        ST_HEADER_CUT     = 4'd5,
        ST_OVERRUN        = 4'd6,
        ST_FIRST_NOT_JSON = 4'd7,
        ST_DUP_JSON       = 4'd8,
        ST_DUP_BIN        = 4'd9,
        ST_NO_JSON        = 4'd10
    } status_t;

    typedef enum logic [1:0] {
        HE_NONE    = 2'd0,
        HE_MAGIC   = 2'd1,
        HE_VERSION = 2'd2,
        HE_LENGTH  = 2'd3
    } hdr_err_t;

    typedef enum logic [1:0] {
        CLS_JSON    = 2'd0,
        CLS_BIN     = 2'd1,
        CLS_UNKNOWN = 2'd2
    } chunk_class_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       last;
        status_t    status;
        kind_t      kind;
        logic [7:0] data;
    } result_t;

endpackage

>>> design/glbcp_in_stage.sv
// ----------------------------------------------------------------------------
// glbcp_in_stage
// Input register: holds one accepted byte until the parse step consumes it.
// ----------------------------------------------------------------------------
module glbcp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  glbcp_pkg::in_item_t s_item,
    input  logic                take,
    output logic                item_valid,
    output glbcp_pkg::in_item_t item
);
    import glbcp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/glbcp_parse_core.sv
// ----------------------------------------------------------------------------
// glbcp_parse_core
// Container parse state and the combinational step that tags one byte.
// ----------------------------------------------------------------------------
module glbcp_parse_core #(
    parameter int LENGTH_WIDTH = glbcp_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  glbcp_pkg::in_item_t item,
    output glbcp_pkg::result_t  result
);
    import glbcp_pkg::*;

    localparam int              CW          = LENGTH_WIDTH + 1;
    localparam logic [CW-1:0]   COUNT_LIMIT = {1'b1, {LENGTH_WIDTH{1'b0}}};
    localparam logic [32:0]     TOTAL_LIMIT = 33'(COUNT_LIMIT);

    // state
    logic [CW-1:0]           count_reg,  count_next;
    phase_t                  phase_reg,  phase_next;
    logic [31:0]             shift_reg,  shift_next;
    logic [2:0]              fpos_reg,   fpos_next;
    logic [LENGTH_WIDTH-1:0] total_reg,  total_next;
    hdr_err_t                herr_reg,   herr_next;
    logic [LENGTH_WIDTH-1:0] remain_reg, remain_next;
    logic [31:0]             clen_reg,   clen_next;
    chunk_class_t            class_reg,  class_next;
    logic                    first_reg,  first_next;
    logic                    json_reg,   json_next;
    logic                    bin_reg,    bin_next;
    status_t                 cerr_reg,   cerr_next;

    // step decisions
    logic [1:0]              byte_pos;
    logic [31:0]             shift_new;
    logic [CW-1:0]           total_ext;
    logic [CW-1:0]           head_room;
    logic [CW-1:0]           room;
    logic                    magic_bad, version_bad, len_at, len_big;
    logic                    past_end, hdr_cut, ch_ok, ch_end;
    logic                    type_json, type_bin;
    status_t                 ch_fault;
    logic [LENGTH_WIDTH-1:0] remain_dec;

    always_comb begin
        byte_pos  = (phase_reg == PH_HEADER) ? count_reg[1:0] : fpos_reg[1:0];
        shift_new = ((byte_pos == 2'd0) ? 32'd0 : shift_reg)
                  | (32'(item.data) << {byte_pos, 3'b000});
        total_ext = {1'b0, total_reg};

        magic_bad   = (count_reg == CW'(3)) && (shift_new != GLB_MAGIC);
        version_bad = (count_reg == CW'(7)) && (shift_new != GLB_VERSION);
        len_at      = (count_reg == CW'(HEADER_BYTES - 1));
        len_big     = len_at && ({1'b0, shift_new} >= TOTAL_LIMIT);

        // a chunk header may only start with all eight bytes inside the total
        past_end  = count_reg >= total_ext;
        head_room = total_ext - count_reg;
        hdr_cut   = !past_end && (head_room < CW'(CHUNK_HEADER_BYTES));
        ch_ok     = !((fpos_reg == 3'd0) && (past_end || hdr_cut));
        ch_end    = ch_ok && (fpos_reg == 3'd7);
        room      = head_room - CW'(1);

        type_json = (shift_new == TYPE_JSON);
        type_bin  = (shift_new == TYPE_BIN);
        if ({1'b0, clen_reg} > 33'(room)) begin
            ch_fault = ST_OVERRUN;
        end else if (first_reg && !type_json) begin
            ch_fault = ST_FIRST_NOT_JSON;
        end else if (type_json && json_reg) begin
            ch_fault = ST_DUP_JSON;
        end else if (type_bin && bin_reg) begin
            ch_fault = ST_DUP_BIN;
        end else begin
            ch_fault = ST_OK;
        end

        remain_dec = remain_reg - LENGTH_WIDTH'(1);
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (magic_bad || version_bad || len_big) begin
                    phase_next = PH_ERROR;
                end else if (len_at) begin
                    phase_next = PH_CHUNK_HEADER;
                end
            end
            PH_CHUNK_HEADER: begin
                if (!ch_ok) begin
                    phase_next = PH_ERROR;
                end else if (ch_end) begin
                    if (ch_fault != ST_OK) begin
                        phase_next = PH_ERROR;
                    end else if (clen_reg == 32'd0) begin
                        phase_next = PH_CHUNK_HEADER;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (remain_dec == '0) begin
                    phase_next = PH_CHUNK_HEADER;
                end
            end
            PH_ERROR: begin
                phase_next = PH_ERROR;
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // datapath state
    always_comb begin
        count_next  = (count_reg == COUNT_LIMIT) ? count_reg : count_reg + CW'(1);
        shift_next  = shift_reg;
        fpos_next   = fpos_reg;
        total_next  = total_reg;
        herr_next   = herr_reg;
        remain_next = remain_reg;
        clen_next   = clen_reg;
        class_next  = class_reg;
        first_next  = first_reg;
        json_next   = json_reg;
        bin_next    = bin_reg;
        cerr_next   = cerr_reg;

        case (phase_reg)
            PH_HEADER: begin
                shift_next = shift_new;
                if (magic_bad) begin
                    herr_next = HE_MAGIC;
                end else if (version_bad) begin
                    herr_next = HE_VERSION;
                end else if (len_at) begin
                    total_next = shift_new[LENGTH_WIDTH-1:0];
                    if (len_big) begin
                        herr_next = HE_LENGTH;
                    end
                end
            end
            PH_CHUNK_HEADER: begin
                if (!ch_ok) begin
                    if (hdr_cut) begin
                        cerr_next = ST_HEADER_CUT;
                    end
                end else begin
                    shift_next = shift_new;
                    fpos_next  = fpos_reg + 3'd1;
                    if (fpos_reg == 3'd3) begin
                        clen_next = shift_new;
                    end
                    if (ch_end) begin
                        if (ch_fault != ST_OK) begin
                            cerr_next = ch_fault;
                        end else begin
                            first_next  = 1'b0;
                            remain_next = clen_reg[LENGTH_WIDTH-1:0];
                            if (type_json) begin
                                json_next  = 1'b1;
                                class_next = CLS_JSON;
                            end else if (type_bin) begin
                                bin_next   = 1'b1;
                                class_next = CLS_BIN;
                            end else begin
                                class_next = CLS_UNKNOWN;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                remain_next = remain_dec;
            end
            default: begin
            end
        endcase
    end

    // result for this byte
    always_comb begin
        result.data   = item.data;
        result.last   = item.last;
        result.kind   = KIND_AFTER_ERROR;
        result.status = ST_OK;

        unique case (phase_reg)
            PH_HEADER:       result.kind = KIND_HEADER;
            PH_CHUNK_HEADER: result.kind = ch_ok ? KIND_HEADER : KIND_AFTER_ERROR;
            PH_PAYLOAD: begin
                unique case (class_reg)
                    CLS_JSON: result.kind = KIND_JSON;
                    CLS_BIN:  result.kind = KIND_BIN;
                    default:  result.kind = KIND_SKIP;
                endcase
            end
            default:         result.kind = KIND_AFTER_ERROR;
        endcase

        if (item.last) begin
            if (count_next < CW'(HEADER_BYTES)) begin
                result.status = ST_SHORT;
            end else if (herr_next == HE_MAGIC) begin
                result.status = ST_MAGIC;
            end else if (herr_next == HE_VERSION) begin
                result.status = ST_VERSION;
            end else if (herr_next == HE_LENGTH) begin
                result.status = ST_LENGTH;
            end else if (count_next != {1'b0, total_next}) begin
                result.status = ST_LENGTH;
            end else if (cerr_next != ST_OK) begin
                result.status = cerr_next;
            end else if (!json_next) begin
                result.status = ST_NO_JSON;
            end
        end
    end

    // the final byte of a file returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last)) begin
            count_reg  <= '0;
            phase_reg  <= PH_HEADER;
            shift_reg  <= '0;
            fpos_reg   <= '0;
            total_reg  <= '0;
            herr_reg   <= HE_NONE;
            remain_reg <= '0;
            clen_reg   <= '0;
            class_reg  <= CLS_JSON;
            first_reg  <= 1'b1;
            json_reg   <= 1'b0;
            bin_reg    <= 1'b0;
            cerr_reg   <= ST_OK;
        end else if (fire) begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            fpos_reg   <= fpos_next;
            total_reg  <= total_next;
            herr_reg   <= herr_next;
            remain_reg <= remain_next;
            clen_reg   <= clen_next;
            class_reg  <= class_next;
            first_reg  <= first_next;
            json_reg   <= json_next;
            bin_reg    <= bin_next;
            cerr_reg   <= cerr_next;
        end
    end

endmodule

>>> design/glbcp_out_stage.sv
// ----------------------------------------------------------------------------
// glbcp_out_stage
// Result register: holds a tagged byte until the receiver takes it.
// ----------------------------------------------------------------------------
module glbcp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  glbcp_pkg::result_t load_result,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output glbcp_pkg::result_t m_result
);
    import glbcp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

>>> design/glb_container_chunk_parser.sv
// ----------------------------------------------------------------------------
// glb_container_chunk_parser
// Byte-stream checker and tagger for a glTF binary container.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one container byte per transaction; s_tlast marks the
//   final byte of a file. Master side returns every byte with a tag on
//   m_tuser (header, JSON, BIN, skipped chunk, after error). On the final
//   byte (m_tlast) m_tdata[11:8] carries the file status; it is zero on all
//   other transactions.
//   An input transaction is captured in the input register; the parse step
//   reads that register and loads the result register once the result
//   register is free, and the result transaction is taken from there.
//   Throughput is one byte per cycle while m_tready stays high; the parse
//   step only updates counters and compares words, so nothing loops per byte.
//   aresetn (synchronous) empties both registers and returns the parser to
//   the start of a file. The byte after a final byte also starts a new file.
//   When m_tready is low the result register holds; the input register
//   still takes one more byte, then s_tready drops until the result moves.
// ----------------------------------------------------------------------------
module glb_container_chunk_parser #(
    parameter int LENGTH_WIDTH = glbcp_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [glbcp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [glbcp_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [11:8] status
    output logic [glbcp_pkg::M_TUSER_W-1:0]  m_tuser,   // [2:0] byte_kind
    output logic                             m_tlast
);
    import glbcp_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    result_t  step_result;
    result_t  m_result;

    assign s_item.data = s_tdata;
    assign s_item.last = s_tlast;
    assign fire        = item_valid && out_free;

    glbcp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    glbcp_parse_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (step_result)
    );

    glbcp_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire),
        .load_result (step_result),
        .free        (out_free),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {4'b0000, m_result.status, m_result.data};
    assign m_tuser = m_result.kind;
    assign m_tlast = m_result.last;

endmodule

>>> design/glbcp_checker.sv
// ----------------------------------------------------------------------------
// glbcp_checker
// Port-level checks for the GLB container chunk parser, bound to the top.
// ----------------------------------------------------------------------------
module glbcp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [glbcp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [glbcp_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                             m_tlast
);
    import glbcp_pkg::*;

    // no result may survive a reset cycle
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // status only on the final byte of a file
    a_status_final_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[11:8] == ST_OK))
        else $error("nonzero status on a non-final transaction");

    // a clean file never ends on a byte tagged after-error
    a_ok_not_error_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && (m_tdata[11:8] == ST_OK)) |->
            (m_tuser != KIND_AFTER_ERROR))
        else $error("ok status on an after-error byte");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind glb_container_chunk_parser glbcp_checker u_glbcp_checker (.*);

>>> test/tb_glb_container_chunk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glb_container_chunk_parser
// Streams GLB container files byte by byte through the parser and checks
// every tagged byte and the final status against an in-bench parser model.
// The files are valid ones with random content, plus damaged ones: bad
// magic, bad version, wrong declared length, cut or overrunning chunk
// headers, bad chunk order, truncation and noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_glb_container_chunk_parser;
    import glbcp_pkg::*;

    localparam int          LW          = LENGTH_WIDTH_DEF;
    localparam logic [63:0] COUNT_CAP   = 64'd1 << LW;
    localparam int          RANDOM_BYTES = 1650;
    localparam int          QUIET_LIMIT = 1000;
    localparam int          TAIL_CYCLES = 8;

    typedef struct packed {
        logic     drain_first;
        in_item_t item;
    } byte_slot_t;

    typedef enum int {
        SHAPE_VALID, SHAPE_BAD_MAGIC, SHAPE_BAD_VERSION, SHAPE_LONG_DECL,
        SHAPE_SHORT_DECL, SHAPE_CUT_HEADER, SHAPE_OVERRUN, SHAPE_BAD_ORDER,
        SHAPE_NOISE, SHAPE_TRUNCATED
    } file_shape_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    always #1 aclk = ~aclk;

    glb_container_chunk_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    byte_slot_t  byte_feed_q[$];
    result_t     tagged_q[$];
    logic [7:0]  file_bytes[$];
    int unsigned fed_count    = 0;
    int unsigned result_count = 0;
    int          err_count    = 0;
    int          quiet_cycles = 0;
    logic        in_accepted  = 1'b0;
    logic        out_accepted = 1'b0;

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    logic [LW:0]  seen_bytes;
    phase_t       ph;
    logic [31:0]  word_acc;
    logic [2:0]   hdr_pos;
    logic [31:0]  decl_len;
    hdr_err_t     hdr_fault;
    logic [31:0]  payload_left;
    logic [31:0]  chunk_len;
    chunk_class_t cls;
    logic         first_pending;
    logic         json_done;
    logic         bin_done;
    status_t      chunk_fault;

    function automatic void parser_clear();
        seen_bytes    = '0;
        ph            = PH_HEADER;
        word_acc      = '0;
        hdr_pos       = '0;
        decl_len      = '0;
        hdr_fault     = HE_NONE;
        payload_left  = '0;
        chunk_len     = '0;
        cls           = CLS_JSON;
        first_pending = 1'b1;
        json_done     = 1'b0;
        bin_done      = 1'b0;
        chunk_fault   = ST_OK;
    endfunction

    // little-endian word assembly, restarts every fourth byte
    function automatic void gather_byte(input logic [2:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0)
            word_acc = '0;
        word_acc = word_acc | (32'(b) << (8 * pos[1:0]));
    endfunction

    function automatic void close_chunk_header(input logic [63:0] next_off);
        logic [31:0] ctype;
        logic [63:0] room;
        status_t     fault;
        ctype = word_acc;
        room  = 64'(decl_len) - next_off;
        fault = ST_OK;
        if (64'(chunk_len) > room) begin
            fault = ST_OVERRUN;
        end else if (first_pending && ctype != TYPE_JSON) begin
            fault = ST_FIRST_NOT_JSON;
        end else if (ctype == TYPE_JSON) begin
            if (json_done) begin
                fault = ST_DUP_JSON;
            end else begin
                json_done = 1'b1;
                cls = CLS_JSON;
            end
        end else if (ctype == TYPE_BIN) begin
            if (bin_done) begin
                fault = ST_DUP_BIN;
            end else begin
                bin_done = 1'b1;
                cls = CLS_BIN;
            end
        end else begin
            cls = CLS_UNKNOWN;
        end
        if (fault != ST_OK) begin
            chunk_fault = fault;
            ph = PH_ERROR;
        end else begin
            first_pending = 1'b0;
            payload_left  = chunk_len;
            hdr_pos       = '0;
            ph = (chunk_len == 0) ? PH_CHUNK_HEADER : PH_PAYLOAD;
        end
    endfunction

    function automatic result_t glb_tag_byte(input in_item_t it);
        logic [63:0] idx;
        logic [63:0] n;
        logic        ok;
        result_t     r;
        idx      = 64'(seen_bytes);
        r.data   = it.data;
        r.kind   = KIND_AFTER_ERROR;
        r.last   = it.last;
        r.status = ST_OK;
        if (64'(seen_bytes) < COUNT_CAP)
            seen_bytes = seen_bytes + 1'b1;

        case (ph)
            PH_HEADER: begin
                r.kind = KIND_HEADER;
                gather_byte(3'(idx[1:0]), it.data);
                // byte offsets 3, 7, 11 close the magic, version and length words
                if (idx == 3 && word_acc != GLB_MAGIC) begin
                    hdr_fault = HE_MAGIC;
                    ph = PH_ERROR;
                end else if (idx == 7 && word_acc != GLB_VERSION) begin
                    hdr_fault = HE_VERSION;
                    ph = PH_ERROR;
                end else if (idx == 11) begin
                    decl_len = word_acc;
                    if (64'(decl_len) >= COUNT_CAP) begin
                        hdr_fault = HE_LENGTH;
                        ph = PH_ERROR;
                    end else begin
                        ph = PH_CHUNK_HEADER;
                        hdr_pos = '0;
                    end
                end
            end
            PH_CHUNK_HEADER: begin
                ok = 1'b1;
                if (hdr_pos == 0) begin
                    if (idx >= 64'(decl_len)) begin
                        ph = PH_ERROR;
                        ok = 1'b0;
                    end else if (64'(decl_len) - idx < CHUNK_HEADER_BYTES) begin
                        chunk_fault = ST_HEADER_CUT;
                        ph = PH_ERROR;
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    r.kind = KIND_HEADER;
                    gather_byte(hdr_pos, it.data);
                    if (hdr_pos == 3)
                        chunk_len = word_acc;
                    if (hdr_pos == 7)
                        close_chunk_header(idx + 1);
                    else
                        hdr_pos = hdr_pos + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                r.kind = kind_t'(3'(cls) + 3'd1);
                payload_left = payload_left - 32'd1;
                if (payload_left == 0) begin
                    ph = PH_CHUNK_HEADER;
                    hdr_pos = '0;
                end
            end
            default: ;
        endcase

        if (it.last) begin
            n = 64'(seen_bytes);
            if (n < HEADER_BYTES)             r.status = ST_SHORT;
            else if (hdr_fault == HE_MAGIC)   r.status = ST_MAGIC;
            else if (hdr_fault == HE_VERSION) r.status = ST_VERSION;
            else if (hdr_fault == HE_LENGTH)  r.status = ST_LENGTH;
            else if (n != 64'(decl_len))      r.status = ST_LENGTH;
            else if (chunk_fault != ST_OK)    r.status = chunk_fault;
            else if (!json_done)              r.status = ST_NO_JSON;
            else                              r.status = ST_OK;
            parser_clear();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------------
    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic put_chunk(input logic [31:0] ctype, input logic [31:0] len_field,
                             input int n_pay);
        put_word(len_field);
        put_word(ctype);
        repeat (n_pay) file_bytes.push_back(8'($urandom));
    endtask

    task automatic begin_file();
        file_bytes.delete();
        put_word(GLB_MAGIC);
        put_word(GLB_VERSION);
        put_word(32'd0);
    endtask

    task automatic set_declared(input logic [31:0] total);
        for (int i = 0; i < 4; i++)
            file_bytes[8 + i] = total[8*i +: 8];
    endtask

    task automatic queue_file(input bit drain);
        byte_slot_t slot;
        foreach (file_bytes[i]) begin
            slot.drain_first = drain && (i == 0);
            slot.item.data   = file_bytes[i];
            slot.item.last   = (i == file_bytes.size() - 1);
            byte_feed_q.push_back(slot);
        end
        fed_count += file_bytes.size();
    endtask

    function automatic int payload_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    endfunction

    // type word that is neither JSON nor BIN; half of them one bit away
    function automatic logic [31:0] odd_type();
        logic [31:0] t;
        case ($urandom_range(0, 3))
            0:       t = TYPE_JSON ^ (32'd1 << $urandom_range(0, 31));
            1:       t = TYPE_BIN ^ (32'd1 << $urandom_range(0, 31));
            default: t = $urandom;
        endcase
        if (t == TYPE_JSON || t == TYPE_BIN)
            t = t ^ 32'h8000_0000;
        return t;
    endfunction

    task automatic put_valid_body();
        int len;
        bit bin_used;
        len = payload_len();
        put_chunk(TYPE_JSON, len, len);
        bin_used = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            len = payload_len();
            if (!bin_used && $urandom_range(0, 1)) begin
                put_chunk(TYPE_BIN, len, len);
                bin_used = 1'b1;
            end else begin
                put_chunk(odd_type(), len, len);
            end
        end
    endtask

    task automatic make_random_file(input bit drain);
        int          r;
        int          k;
        int          p;
        int          len;
        file_shape_t shape;
        r = $urandom_range(0, 19);
        shape = (r < 11) ? SHAPE_VALID : file_shape_t'(r - 10);
        begin_file();
        case (shape)
            SHAPE_VALID: begin
                put_valid_body();
                set_declared(file_bytes.size());
            end
            SHAPE_BAD_MAGIC, SHAPE_BAD_VERSION: begin
                put_valid_body();
                set_declared(file_bytes.size());
                k = (shape == SHAPE_BAD_MAGIC) ? $urandom_range(0, 3) : $urandom_range(4, 7);
                file_bytes[k] = file_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            SHAPE_LONG_DECL: begin
                put_valid_body();
                if ($urandom_range(0, 3) == 0)
                    set_declared(32'hFFFF_FFFF);
                else
                    set_declared(file_bytes.size() + $urandom_range(1, 20));
            end
            SHAPE_SHORT_DECL: begin
                put_valid_body();
                if ($urandom_range(0, 1)) begin
                    // trailing bytes beyond the declared end
                    set_declared(file_bytes.size());
                    repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
                end else begin
                    set_declared($urandom_range(0, file_bytes.size() - 1));
                end
            end
            SHAPE_CUT_HEADER: begin
                put_valid_body();
                repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
                set_declared(file_bytes.size());
            end
            SHAPE_OVERRUN: begin
                if ($urandom_range(0, 3) != 0)
                    put_valid_body();
                p = $urandom_range(0, 8);
                case ($urandom_range(0, 2))
                    0:       put_chunk(TYPE_JSON, p + $urandom_range(1, 8), p);
                    1:       put_chunk(TYPE_BIN, p + $urandom_range(1, 8), p);
                    default: put_chunk(odd_type(), p + $urandom_range(1, 8), p);
                endcase
                set_declared(file_bytes.size());
            end
            SHAPE_BAD_ORDER: begin
                len = payload_len();
                case ($urandom_range(0, 3))
                    0: begin
                        put_chunk($urandom_range(0, 1) ? TYPE_BIN : odd_type(), len, len);
                        if ($urandom_range(0, 1))
                            put_valid_body();
                    end
                    1: begin
                        put_valid_body();
                        put_chunk(TYPE_JSON, len, len);
                    end
                    2: begin
                        put_chunk(TYPE_JSON, len, len);
                        len = payload_len();
                        put_chunk(TYPE_BIN, len, len);
                        len = payload_len();
                        put_chunk(TYPE_BIN, len, len);
                    end
                    default: ; // header only, no JSON chunk at all
                endcase
                set_declared(file_bytes.size());
            end
            SHAPE_NOISE: begin
                file_bytes.delete();
                repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
            end
            default: begin
                put_valid_body();
                set_declared(file_bytes.size());
                k = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > k)
                    void'(file_bytes.pop_back());
            end
        endcase
        queue_file(drain);
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern: runs of items either without gaps or with random gaps
    // ------------------------------------------------------------------------
    function automatic int pick_wait(inout int run_left, inout bit no_idle);
        if (run_left == 0) begin
            run_left = $urandom_range(20, 80);
            no_idle  = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= 100)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Byte feeder (slave side)
    // ------------------------------------------------------------------------
    in_item_t feed_item  = '0;
    logic     feed_busy  = 1'b0;
    int       feed_gap   = 0;
    int       feed_run   = 0;
    bit       feed_calm  = 1'b0;

    always @(negedge aclk) begin
        byte_slot_t slot;
        if (aresetn) begin
            if (in_accepted)
                feed_busy = 1'b0;
            if (!feed_busy) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (byte_feed_q.size() > 0 &&
                             (!byte_feed_q[0].drain_first || tagged_q.size() == 0)) begin
                    slot      = byte_feed_q.pop_front();
                    feed_item = slot.item;
                    feed_busy = 1'b1;
                    feed_gap  = pick_wait(feed_run, feed_calm);
                end
            end
        end
        s_tvalid <= feed_busy;
        s_tdata  <= feed_item.data;
        s_tlast  <= feed_item.last;
    end

    // ------------------------------------------------------------------------
    // Result sink (master side)
    // ------------------------------------------------------------------------
    int sink_stall = 0;
    int sink_run   = 0;
    bit sink_calm  = 1'b0;

    always @(negedge aclk) begin
        if (aresetn && out_accepted)
            sink_stall = pick_wait(sink_run, sink_calm);
        else if (sink_stall > 0)
            sink_stall--;
        m_tready <= aresetn && (sink_stall == 0);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transactions, check on output transactions
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        logic    s_fire;
        logic    m_fire;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        in_accepted  <= s_fire;
        out_accepted <= m_fire;

        if (s_fire)
            tagged_q.push_back(glb_tag_byte(in_item_t'({s_tlast, s_tdata})));

        if (m_fire) begin
            if (tagged_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                        result_count));
            end else begin
                want = tagged_q.pop_front();
                if (m_tdata[7:0] != want.data)
                    flag_mismatch($sformatf("result %0d: out_byte %h, want %h",
                                            result_count, m_tdata[7:0], want.data));
                if (m_tdata[11:8] != want.status)
                    flag_mismatch($sformatf("result %0d: status %0d, want %0d",
                                            result_count, m_tdata[11:8], want.status));
                if (m_tdata[M_TDATA_W-1:12] != '0)
                    flag_mismatch($sformatf("result %0d: tdata pad bits %h not zero",
                                            result_count, m_tdata[M_TDATA_W-1:12]));
                if (m_tuser != want.kind)
                    flag_mismatch($sformatf("result %0d: byte_kind %0d, want %0d",
                                            result_count, m_tuser, want.kind));
                if (m_tlast != want.last)
                    flag_mismatch($sformatf("result %0d: tlast %b, want %b",
                                            result_count, m_tlast, want.last));
            end
            result_count++;
        end

        quiet_cycles = (s_fire || m_fire || !aresetn) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_glb_container_chunk_parser: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        bit first;
        parser_clear();

        // one-byte files at both byte extremes, then the smallest valid file
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        queue_file(1'b0);
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        queue_file(1'b0);
        begin_file();
        put_chunk(TYPE_JSON, 32'd0, 0);
        set_declared(file_bytes.size());
        queue_file(1'b0);

        first = 1'b1;
        while (fed_count < 22 + RANDOM_BYTES) begin
            make_random_file(first || $urandom_range(0, 7) == 0);
            first = 1'b0;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (byte_feed_q.size() != 0 || feed_busy)
            @(posedge aclk);
        while (tagged_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("tb_glb_container_chunk_parser: done, clean");
        else
            $display("tb_glb_container_chunk_parser: done, errors");
        $finish;
    end

endmodule
